// ----- src/bqcg_pkg.sv -----
`default_nettype none

package bqcg_pkg;

    localparam int CORDIC_STEPS   = 24;
    localparam int COEF_FRAC_BITS = 29;

    localparam int FS_W     = 18;
    localparam int FC_W     = 17;
    localparam int Q_W      = 16;
    localparam int PHASE_W  = 32;
    localparam int XY_W     = 34;
    localparam int Z_W      = 33;
    localparam int STEP_W   = 5;
    localparam int ALPHA_SH = 7;
    localparam int ALPHA_W  = 38;
    localparam int A0_W     = 39;
    localparam int CQ_W     = 32;
    localparam int LANES    = 4;
    localparam int V_W      = XY_W + 1;
    localparam int D_W      = V_W + COEF_FRAC_BITS;
    localparam int COEF_W   = 32;
    localparam int RES_W    = CQ_W + 2;
    localparam int SCALE_W  = FC_W + 10;

    localparam logic [FS_W-1:0]    RATE_RESET  = 18'd48000;
    localparam logic [PHASE_W-1:0] CLAMP_PHASE = 32'd1052266987;
    localparam logic [SCALE_W-1:0] FC_SCALE    = 27'd1000;
    localparam logic [SCALE_W-1:0] FS_SCALE    = 27'd245;
    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    localparam logic [PHASE_W-1:0] CORDIC_ANGLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic                hp;
        logic                pass;
        logic                clamp;
        logic [FS_W-1:0]     fs;
        logic [Q_W-1:0]      quality;
        logic [FS_W-1:0]     rem;
        logic [PHASE_W-1:0]  quo;
    } phase_item_t;

    typedef struct packed {
        logic                   hp;
        logic                   pass;
        logic [Q_W-1:0]         quality;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_item_t;

    typedef struct packed {
        logic                   hp;
        logic                   pass;
        logic signed [XY_W-1:0] c;
        logic [Q_W-1:0]         quality;
        logic [Q_W-1:0]         rem;
        logic [ALPHA_W-1:0]     acc;
    } alpha_item_t;

    typedef struct packed {
        logic                   hp;
        logic                   pass;
        logic signed [V_W-1:0]  c;
        logic signed [V_W-1:0]  n;
        logic [A0_W-1:0]        a0;
    } norm_item_t;

    typedef struct packed {
        logic                            pass;
        logic [LANES-1:0]                neg;
        logic [A0_W-1:0]                 a0;
        logic [LANES-1:0][A0_W-1:0]      rem;
        logic [LANES-1:0][CQ_W-1:0]      acc;
    } coef_item_t;

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [RES_W-1:0] v);
        logic [RES_W-COEF_W:0] top;
        top = v[RES_W-1:COEF_W-1];
        if (top == '0 || top == '1)
            return v[COEF_W-1:0];
        else if (v[RES_W-1])
            return {1'b1, {(COEF_W-1){1'b0}}};
        else
            return {1'b0, {(COEF_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

// ----- src/bqcg_phase_cell.sv -----
`default_nettype none

module bqcg_phase_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   d_valid,
    input  bqcg_pkg::phase_item_t  d,
    output logic                   q_valid,
    output bqcg_pkg::phase_item_t  q
);

    logic                  q_valid_reg;
    logic                  q_valid_next;
    bqcg_pkg::phase_item_t q_reg;
    bqcg_pkg::phase_item_t q_next;
    logic [bqcg_pkg::FS_W:0] trial;
    logic                    ge;

    always_comb
    begin
        trial        = {d.rem, 1'b0};
        ge           = trial >= {1'b0, d.fs};
        q_next       = d;
        q_next.rem   = ge ? bqcg_pkg::FS_W'(trial - {1'b0, d.fs})
                          : trial[bqcg_pkg::FS_W-1:0];
        q_next.quo   = {d.quo[bqcg_pkg::PHASE_W-2:0], ge};
        q_valid_next = d_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (adv)
            q_valid_reg <= q_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    assign q_valid = q_valid_reg;
    assign q       = q_reg;

endmodule

`default_nettype wire

// ----- src/bqcg_cordic_cell.sv -----
`default_nettype none

module bqcg_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [bqcg_pkg::STEP_W-1:0]   step,
    input  logic                          d_valid,
    input  bqcg_pkg::cordic_item_t        d,
    output logic                          q_valid,
    output bqcg_pkg::cordic_item_t        q
);

    logic                             q_valid_reg;
    logic                             q_valid_next;
    bqcg_pkg::cordic_item_t           q_reg;
    bqcg_pkg::cordic_item_t           q_next;
    logic signed [bqcg_pkg::XY_W-1:0] dx;
    logic signed [bqcg_pkg::XY_W-1:0] dy;
    logic signed [bqcg_pkg::Z_W-1:0]  ang;

    always_comb
    begin
        dx     = d.y >>> step;
        dy     = d.x >>> step;
        ang    = signed'(bqcg_pkg::Z_W'(bqcg_pkg::CORDIC_ANGLE[step]));
        q_next = d;
        if (!d.z[bqcg_pkg::Z_W-1])
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - ang;
        end
        else
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + ang;
        end
        q_valid_next = d_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (adv)
            q_valid_reg <= q_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    assign q_valid = q_valid_reg;
    assign q       = q_reg;

endmodule

`default_nettype wire

// ----- src/bqcg_alpha_cell.sv -----
`default_nettype none

module bqcg_alpha_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   d_valid,
    input  bqcg_pkg::alpha_item_t  d,
    output logic                   q_valid,
    output bqcg_pkg::alpha_item_t  q
);

    logic                   q_valid_reg;
    logic                   q_valid_next;
    bqcg_pkg::alpha_item_t  q_reg;
    bqcg_pkg::alpha_item_t  q_next;
    logic [bqcg_pkg::Q_W:0] trial;
    logic                   ge;

    always_comb
    begin
        trial        = {d.rem, d.acc[bqcg_pkg::ALPHA_W-1]};
        ge           = trial >= {1'b0, d.quality};
        q_next       = d;
        q_next.rem   = ge ? bqcg_pkg::Q_W'(trial - {1'b0, d.quality})
                          : trial[bqcg_pkg::Q_W-1:0];
        q_next.acc   = {d.acc[bqcg_pkg::ALPHA_W-2:0], ge};
        q_valid_next = d_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (adv)
            q_valid_reg <= q_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    assign q_valid = q_valid_reg;
    assign q       = q_reg;

endmodule

`default_nettype wire

// ----- src/bqcg_coef_cell.sv -----
`default_nettype none

module bqcg_coef_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  d_valid,
    input  bqcg_pkg::coef_item_t  d,
    output logic                  q_valid,
    output bqcg_pkg::coef_item_t  q
);

    logic                    q_valid_reg;
    logic                    q_valid_next;
    bqcg_pkg::coef_item_t    q_reg;
    bqcg_pkg::coef_item_t    q_next;
    logic [bqcg_pkg::A0_W:0] trial [bqcg_pkg::LANES];
    logic [bqcg_pkg::LANES-1:0] ge;

    always_comb
    begin
        q_next = d;
        for (int k = 0; k < bqcg_pkg::LANES; k++)
        begin
            trial[k]      = {d.rem[k], d.acc[k][bqcg_pkg::CQ_W-1]};
            ge[k]         = trial[k] >= {1'b0, d.a0};
            q_next.rem[k] = ge[k] ? bqcg_pkg::A0_W'(trial[k] - {1'b0, d.a0})
                                  : trial[k][bqcg_pkg::A0_W-1:0];
            q_next.acc[k] = {d.acc[k][bqcg_pkg::CQ_W-2:0], ge[k]};
        end
        q_valid_next = d_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (adv)
            q_valid_reg <= q_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    assign q_valid = q_valid_reg;
    assign q       = q_reg;

endmodule

`default_nettype wire

// ----- src/biquad_coefficient_generator.sv -----
// Lowpass and highpass biquad coefficient generator. Each item carries a filter type, a cutoff
// in whole Hz and a Q in unsigned Q8.8, and yields b0, b1, b2, a1 and a2 in signed Q2.29,
// normalised by a0, for the sample rate held in the configuration register. A new item is
// taken in every cycle unless the chain is halted, and passes in turn through one entry
// stage, 32 cells of the phase divider, 24 CORDIC cells, 38 cells of the alpha divider, two
// normalisation stages, 32 cells of the four-lane coefficient divider and the output register,
// each cell resolving one quotient bit or one rotation. The chain only halts when its last cell
// holds an item and the output register is still waiting to be taken. A sample rate of 1 or
// less, or a Q of zero, gives pass-through coefficients with the passthrough flag set.
`default_nettype none

module biquad_coefficient_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bqcg_pkg::FS_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic [bqcg_pkg::FC_W-1:0]             cutoff_hz,
    input  logic [bqcg_pkg::Q_W-1:0]              quality,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bqcg_pkg::COEF_W-1:0]    coef_b0,
    output logic signed [bqcg_pkg::COEF_W-1:0]    coef_b1,
    output logic signed [bqcg_pkg::COEF_W-1:0]    coef_b2,
    output logic signed [bqcg_pkg::COEF_W-1:0]    coef_a1,
    output logic signed [bqcg_pkg::COEF_W-1:0]    coef_a2,
    output logic                                  passthrough
);

    logic [bqcg_pkg::FS_W-1:0] sample_rate_hz_reg;
    logic                      adv;
    logic                      out_load;

    logic                           ph_v [bqcg_pkg::PHASE_W+1];
    bqcg_pkg::phase_item_t          ph_d [bqcg_pkg::PHASE_W+1];
    logic                           co_v [bqcg_pkg::CORDIC_STEPS+1];
    bqcg_pkg::cordic_item_t         co_d [bqcg_pkg::CORDIC_STEPS+1];
    logic                           al_v [bqcg_pkg::ALPHA_W+1];
    bqcg_pkg::alpha_item_t          al_d [bqcg_pkg::ALPHA_W+1];
    logic                           cf_v [bqcg_pkg::CQ_W+1];
    bqcg_pkg::coef_item_t           cf_d [bqcg_pkg::CQ_W+1];

    logic                          entry_valid_reg;
    bqcg_pkg::phase_item_t         entry_reg;
    bqcg_pkg::phase_item_t         entry_next;
    logic [bqcg_pkg::FC_W-1:0]     fc;

    logic                          norm_valid_reg;
    bqcg_pkg::norm_item_t          norm_reg;
    bqcg_pkg::norm_item_t          norm_next;

    logic                          prep_valid_reg;
    bqcg_pkg::coef_item_t          prep_reg;
    bqcg_pkg::coef_item_t          prep_next;
    logic signed [bqcg_pkg::V_W-1:0] lane_v   [bqcg_pkg::LANES];
    logic [bqcg_pkg::V_W-1:0]        lane_mag [bqcg_pkg::LANES];
    logic [bqcg_pkg::D_W-1:0]        lane_d   [bqcg_pkg::LANES];

    logic                                 out_valid_reg;
    logic signed [bqcg_pkg::COEF_W-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                                 pass_reg;
    logic signed [bqcg_pkg::COEF_W-1:0]   b0_next, b1_next, a1_next, a2_next;
    logic signed [bqcg_pkg::RES_W-1:0]    res [bqcg_pkg::LANES];
    logic [bqcg_pkg::RES_W-1:0]           qmag [bqcg_pkg::LANES];

    assign cfg_ready = 1'b1;
    assign out_load  = !out_valid_reg || out_ready;
    assign adv       = out_load || !cf_v[bqcg_pkg::CQ_W];
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_rate_hz_reg <= bqcg_pkg::RATE_RESET;
        else if (cfg_valid && cfg_ready)
            sample_rate_hz_reg <= cfg_data;
    end

    always_comb
    begin
        fc               = (cutoff_hz == '0) ? bqcg_pkg::FC_W'(1) : cutoff_hz;
        entry_next.hp    = cmd;
        entry_next.pass  = (sample_rate_hz_reg <= bqcg_pkg::FS_W'(1)) || (quality == '0);
        entry_next.clamp = (bqcg_pkg::SCALE_W'(fc) * bqcg_pkg::FC_SCALE)
                         > (bqcg_pkg::SCALE_W'(sample_rate_hz_reg) * bqcg_pkg::FS_SCALE);
        entry_next.fs      = sample_rate_hz_reg;
        entry_next.quality = quality;
        entry_next.rem     = bqcg_pkg::FS_W'(fc);
        entry_next.quo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else if (adv)
            entry_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            entry_reg <= entry_next;
    end

    assign ph_v[0] = entry_valid_reg;
    assign ph_d[0] = entry_reg;

    for (genvar i = 0; i < bqcg_pkg::PHASE_W; i++)
    begin : g_phase
        bqcg_phase_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .d_valid (ph_v[i]),
            .d       (ph_d[i]),
            .q_valid (ph_v[i+1]),
            .q       (ph_d[i+1])
        );
    end

    always_comb
    begin
        co_v[0]         = ph_v[bqcg_pkg::PHASE_W];
        co_d[0].hp      = ph_d[bqcg_pkg::PHASE_W].hp;
        co_d[0].pass    = ph_d[bqcg_pkg::PHASE_W].pass;
        co_d[0].quality = ph_d[bqcg_pkg::PHASE_W].quality;
        co_d[0].x       = bqcg_pkg::XY_W'(bqcg_pkg::CORDIC_GAIN);
        co_d[0].y       = '0;
        co_d[0].z       = signed'(bqcg_pkg::Z_W'(ph_d[bqcg_pkg::PHASE_W].clamp
                                                 ? bqcg_pkg::CLAMP_PHASE
                                                 : ph_d[bqcg_pkg::PHASE_W].quo));
    end

    for (genvar i = 0; i < bqcg_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        bqcg_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .step    (bqcg_pkg::STEP_W'(i)),
            .d_valid (co_v[i]),
            .d       (co_d[i]),
            .q_valid (co_v[i+1]),
            .q       (co_d[i+1])
        );
    end

    always_comb
    begin
        al_v[0]         = co_v[bqcg_pkg::CORDIC_STEPS];
        al_d[0].hp      = co_d[bqcg_pkg::CORDIC_STEPS].hp;
        al_d[0].pass    = co_d[bqcg_pkg::CORDIC_STEPS].pass;
        al_d[0].c       = co_d[bqcg_pkg::CORDIC_STEPS].x;
        al_d[0].quality = co_d[bqcg_pkg::CORDIC_STEPS].quality;
        al_d[0].rem     = '0;
        al_d[0].acc     = {co_d[bqcg_pkg::CORDIC_STEPS].y[bqcg_pkg::ALPHA_W-bqcg_pkg::ALPHA_SH-1:0],
                           {bqcg_pkg::ALPHA_SH{1'b0}}};
    end

    for (genvar i = 0; i < bqcg_pkg::ALPHA_W; i++)
    begin : g_alpha
        bqcg_alpha_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .d_valid (al_v[i]),
            .d       (al_d[i]),
            .q_valid (al_v[i+1]),
            .q       (al_d[i+1])
        );
    end

    always_comb
    begin
        norm_next.hp   = al_d[bqcg_pkg::ALPHA_W].hp;
        norm_next.pass = al_d[bqcg_pkg::ALPHA_W].pass;
        norm_next.c    = bqcg_pkg::V_W'(al_d[bqcg_pkg::ALPHA_W].c);
        norm_next.a0   = bqcg_pkg::A0_W'(bqcg_pkg::ONE_Q30)
                       + bqcg_pkg::A0_W'(al_d[bqcg_pkg::ALPHA_W].acc);
        if (al_d[bqcg_pkg::ALPHA_W].hp)
            norm_next.n = bqcg_pkg::V_W'(bqcg_pkg::ONE_Q30) + norm_next.c;
        else
            norm_next.n = bqcg_pkg::V_W'(bqcg_pkg::ONE_Q30) - norm_next.c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_valid_reg <= 1'b0;
        else if (adv)
            norm_valid_reg <= al_v[bqcg_pkg::ALPHA_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            norm_reg <= norm_next;
    end

    // The half divisor is added up front so that truncating division rounds to nearest.
    always_comb
    begin
        lane_v[0] = norm_reg.n;
        lane_v[1] = norm_reg.n;
        lane_v[2] = -(norm_reg.c <<< 1);
        lane_v[3] = bqcg_pkg::V_W'(2 * bqcg_pkg::ONE_Q30);
        prep_next.pass = norm_reg.pass;
        prep_next.a0   = norm_reg.a0;
        for (int k = 0; k < bqcg_pkg::LANES; k++)
        begin
            lane_mag[k] = lane_v[k][bqcg_pkg::V_W-1] ? bqcg_pkg::V_W'(-lane_v[k])
                                                      : bqcg_pkg::V_W'(lane_v[k]);
            lane_d[k]   = (bqcg_pkg::D_W'(lane_mag[k])
                           << ((k == 0) ? bqcg_pkg::COEF_FRAC_BITS - 1
                                        : bqcg_pkg::COEF_FRAC_BITS))
                        + bqcg_pkg::D_W'(norm_reg.a0 >> 1);
            prep_next.rem[k] = bqcg_pkg::A0_W'(lane_d[k][bqcg_pkg::D_W-1:bqcg_pkg::CQ_W]);
            prep_next.acc[k] = lane_d[k][bqcg_pkg::CQ_W-1:0];
        end
        prep_next.neg[0] = lane_v[0][bqcg_pkg::V_W-1];
        prep_next.neg[1] = lane_v[1][bqcg_pkg::V_W-1] ^ norm_reg.hp;
        prep_next.neg[2] = lane_v[2][bqcg_pkg::V_W-1];
        prep_next.neg[3] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (adv)
            prep_valid_reg <= norm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            prep_reg <= prep_next;
    end

    assign cf_v[0] = prep_valid_reg;
    assign cf_d[0] = prep_reg;

    for (genvar i = 0; i < bqcg_pkg::CQ_W; i++)
    begin : g_coef
        bqcg_coef_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .d_valid (cf_v[i]),
            .d       (cf_d[i]),
            .q_valid (cf_v[i+1]),
            .q       (cf_d[i+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < bqcg_pkg::LANES; k++)
        begin
            qmag[k] = bqcg_pkg::RES_W'(cf_d[bqcg_pkg::CQ_W].acc[k]);
            res[k]  = cf_d[bqcg_pkg::CQ_W].neg[k] ? signed'(-qmag[k]) : signed'(qmag[k]);
        end
        b0_next = bqcg_pkg::sat_coef(res[0]);
        b1_next = bqcg_pkg::sat_coef(res[1]);
        a1_next = bqcg_pkg::sat_coef(res[2]);
        a2_next = bqcg_pkg::sat_coef(res[3] - (bqcg_pkg::RES_W'(1) << bqcg_pkg::COEF_FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= cf_v[bqcg_pkg::CQ_W];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (cf_d[bqcg_pkg::CQ_W].pass)
            begin
                b0_reg <= bqcg_pkg::COEF_W'(1) << bqcg_pkg::COEF_FRAC_BITS;
                b1_reg <= '0;
                b2_reg <= '0;
                a1_reg <= '0;
                a2_reg <= '0;
            end
            else
            begin
                b0_reg <= b0_next;
                b1_reg <= b1_next;
                b2_reg <= b0_next;
                a1_reg <= a1_next;
                a2_reg <= a2_next;
            end
            pass_reg <= cf_d[bqcg_pkg::CQ_W].pass;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coef_b0     = b0_reg;
    assign coef_b1     = b1_reg;
    assign coef_b2     = b2_reg;
    assign coef_a1     = a1_reg;
    assign coef_a2     = a2_reg;
    assign passthrough = pass_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && cf_v[bqcg_pkg::CQ_W]))
        else $error("Input stalled without a blocked result at the tail.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && passthrough) |->
            (coef_b1 == '0 && coef_b2 == '0 && coef_a1 == '0 && coef_a2 == '0))
        else $error("Pass-through item carries non-zero coefficients.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !passthrough) |-> (coef_b0 == coef_b2))
        else $error("Coefficients b0 and b2 differ.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cf_v[bqcg_pkg::CQ_W] && !adv) |=> cf_v[bqcg_pkg::CQ_W])
        else $error("Item lost at the tail of the chain while stalled.");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;

    localparam logic CMD_LOWPASS  = 1'b0;
    localparam logic CMD_HIGHPASS = 1'b1;
    localparam int   LATENCY      = 130;
    localparam longint CYCLE_LIMIT = 900000;

    typedef struct {
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic               pass;
    } coef_set_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [bqcg_pkg::FS_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic cmd;
    logic [bqcg_pkg::FC_W-1:0] cutoff_hz;
    logic [bqcg_pkg::Q_W-1:0] quality;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic passthrough;

    coef_set_t pending_coefs[$];
    logic [bqcg_pkg::FS_W-1:0] rate_hz;
    int fail_count;
    bit send_gaps;
    bit sink_gaps;
    longint cycle_count;

    biquad_coefficient_generator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .cutoff_hz(cutoff_hz), .quality(quality),
        .out_valid(out_valid), .out_ready(out_ready),
        .coef_b0(coef_b0), .coef_b1(coef_b1), .coef_b2(coef_b2),
        .coef_a1(coef_a1), .coef_a2(coef_a2), .passthrough(passthrough)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint rounded_div(longint n, int sh, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = ((mag << sh) + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic coef_set_t design_biquad(logic hp, logic [bqcg_pkg::FC_W-1:0] fc_in,
                                                logic [bqcg_pkg::Q_W-1:0] q);
        coef_set_t r;
        longint fc, fs, phase, x, y, z, dx, dy, c, s, alpha, a0, n, b0, b1;
        fs = longint'(rate_hz);
        r.pass = 1'b0;
        if (fs <= 1 || q == 0)
        begin
            r.b0 = 32'sd1 <<< bqcg_pkg::COEF_FRAC_BITS;
            r.b1 = '0;
            r.b2 = '0;
            r.a1 = '0;
            r.a2 = '0;
            r.pass = 1'b1;
            return r;
        end
        fc = (fc_in == 0) ? 64'sd1 : longint'(fc_in);
        if (fc * 1000 > 245 * fs)
            phase = (64'sd245 << 32) / 1000;
        else
            phase = (fc << 32) / fs;
        x = bqcg_pkg::CORDIC_GAIN;
        y = 0;
        z = phase;
        for (int i = 0; i < bqcg_pkg::CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(bqcg_pkg::CORDIC_ANGLE[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(bqcg_pkg::CORDIC_ANGLE[i]);
            end
        end
        c = x;
        s = y;
        alpha = (s * 128) / longint'(q);
        a0 = bqcg_pkg::ONE_Q30 + alpha;
        if (a0 < 1)
            a0 = 1;
        n = hp ? bqcg_pkg::ONE_Q30 + c : bqcg_pkg::ONE_Q30 - c;
        b0 = rounded_div(n, bqcg_pkg::COEF_FRAC_BITS - 1, a0);
        b1 = rounded_div(n, bqcg_pkg::COEF_FRAC_BITS, a0);
        if (hp)
            b1 = -b1;
        r.b0 = clip32(b0);
        r.b1 = clip32(b1);
        r.b2 = clip32(b0);
        r.a1 = clip32(rounded_div(-2 * c, bqcg_pkg::COEF_FRAC_BITS, a0));
        r.a2 = clip32(rounded_div(2 * bqcg_pkg::ONE_Q30, bqcg_pkg::COEF_FRAC_BITS, a0)
                      - (64'sd1 << bqcg_pkg::COEF_FRAC_BITS));
        return r;
    endfunction

    task automatic idle_burst();
        repeat ($urandom_range(1, 15)) @(posedge clk);
    endtask

    task automatic send_request(logic hp, logic [bqcg_pkg::FC_W-1:0] fc,
                                logic [bqcg_pkg::Q_W-1:0] q);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            idle_burst();
        end
        in_valid <= 1'b1;
        cmd <= hp;
        cutoff_hz <= fc;
        quality <= q;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_coefs.push_back(design_biquad(hp, fc, q));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_coefs.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_rate(logic [bqcg_pkg::FS_W-1:0] fs);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= fs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        rate_hz = fs;
    endtask

    task automatic random_request();
        logic [bqcg_pkg::FC_W-1:0] fc;
        logic [bqcg_pkg::Q_W-1:0] q;
        case ($urandom_range(0, 3))
            0: fc = bqcg_pkg::FC_W'($urandom);
            1: fc = bqcg_pkg::FC_W'($urandom_range(0, 30));
            default: fc = bqcg_pkg::FC_W'($urandom_range(0, rate_hz / 4 + 10));
        endcase
        case ($urandom_range(0, 4))
            0: q = bqcg_pkg::Q_W'($urandom);
            1: q = bqcg_pkg::Q_W'($urandom_range(0, 8));
            default: q = bqcg_pkg::Q_W'($urandom_range(64, 2560));
        endcase
        send_request(1'($urandom_range(0, 1)), fc, q);
    endtask

    task automatic test_reset_rate();
        send_request(CMD_LOWPASS, 17'd1000, 16'd181);
        send_request(CMD_HIGHPASS, 17'd1000, 16'd181);
        send_request(CMD_LOWPASS, 17'd0, 16'd256);
        send_request(CMD_HIGHPASS, 17'd131071, 16'd65535);
        send_request(CMD_LOWPASS, 17'd11760, 16'd1);
        send_request(CMD_HIGHPASS, 17'd11761, 16'd1);
        send_request(CMD_LOWPASS, 17'd5000, 16'd0);
        send_request(CMD_HIGHPASS, 17'd1, 16'd65535);
    endtask

    task automatic test_rate_extremes();
        set_rate(18'd0);
        send_request(CMD_LOWPASS, 17'd1000, 16'd256);
        set_rate(18'd1);
        send_request(CMD_HIGHPASS, 17'd1000, 16'd256);
        set_rate(18'd2);
        send_request(CMD_LOWPASS, 17'd1, 16'd256);
        send_request(CMD_HIGHPASS, 17'd0, 16'd1);
        set_rate(18'd262143);
        send_request(CMD_LOWPASS, 17'd131071, 16'd256);
        send_request(CMD_HIGHPASS, 17'd64225, 16'd65535);
        send_request(CMD_LOWPASS, 17'd1, 16'd32768);
    endtask

    task automatic test_random_rates();
        for (int k = 0; k < 6; k++)
        begin
            set_rate(bqcg_pkg::FS_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 262143)
                                                               : $urandom_range(8000, 192000)));
            repeat (200) random_request();
        end
    endtask

    task automatic test_back_pressure_pause();
        set_rate(18'd44100);
        repeat (100) random_request();
        drain();
        repeat (100) random_request();
    endtask

    task automatic test_full_rate();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        set_rate(18'd96000);
        repeat (300) random_request();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = 1'b0;
        cutoff_hz = '0;
        quality = '0;
        out_ready = 1'b0;
        rate_hz = bqcg_pkg::RATE_RESET;
        fail_count = 0;
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_rate();
        test_rate_extremes();
        test_random_rates();
        test_back_pressure_pause();
        test_full_rate();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                idle_burst();
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        coef_set_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_coefs.size() == 0)
            begin
                $error("coefficient set with no request outstanding");
                fail_count++;
            end
            else
            begin
                e = pending_coefs.pop_front();
                if (coef_b0 !== e.b0)
                begin
                    $error("coef_b0 expected %0d got %0d", e.b0, coef_b0);
                    fail_count++;
                end
                if (coef_b1 !== e.b1)
                begin
                    $error("coef_b1 expected %0d got %0d", e.b1, coef_b1);
                    fail_count++;
                end
                if (coef_b2 !== e.b2)
                begin
                    $error("coef_b2 expected %0d got %0d", e.b2, coef_b2);
                    fail_count++;
                end
                if (coef_a1 !== e.a1)
                begin
                    $error("coef_a1 expected %0d got %0d", e.a1, coef_a1);
                    fail_count++;
                end
                if (coef_a2 !== e.a2)
                begin
                    $error("coef_a2 expected %0d got %0d", e.a2, coef_a2);
                    fail_count++;
                end
                if (passthrough !== e.pass)
                begin
                    $error("passthrough expected %0b got %0b", e.pass, passthrough);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/bqcg_pkg.sv
src/bqcg_phase_cell.sv
src/bqcg_cordic_cell.sv
src/bqcg_alpha_cell.sv
src/bqcg_coef_cell.sv
src/biquad_coefficient_generator.sv
tb/tb.sv
